// File: design/arc4_pkg.sv
`default_nettype none

package arc4_pkg;

  localparam int unsigned KeyBytesDef = 256;

  localparam int unsigned OpW      = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned KeyLenW  = 9;
  localparam int unsigned DropW    = 12;
  localparam int unsigned CntW     = 12;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;

  localparam logic [KeyLenW-1:0] KeyLenRst = 9'd128;
  localparam logic [DropW-1:0]   DropRst   = 12'd1024;

  typedef enum logic [OpW-1:0] {
    OP_INIT = 3'd0,
    OP_LOAD = 3'd1,
    OP_STIR = 3'd2,
    OP_DISC = 3'd3,
    OP_GEN  = 3'd4
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_LEN = 2'd0,
    CFG_DROP    = 2'd1
  } cfg_idx_e;

  // commands from controller to datapath
  typedef struct packed {
    logic init;          // identity permutation, i = j = 0
    logic key_wr;        // write one key byte
    logic stir_setup;    // step i back, clear counters
    logic disc_setup;    // clear loop counter
    logic rd_i;          // i++, read s[i], read key byte
    logic rd_j;          // latch a, update j, read s[j]
    logic use_key;       // add key byte into j
    logic wr_i;          // latch b, write s[i] = b, read s[a+b]
    logic wr_j;          // write s[j] = a, count the step
    logic stir_end;      // j = i, clear loop counter
    logic cnt_clr;       // clear loop counter
    logic out_ld;        // load output register
    logic out_from_res;  // output from the held result
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic stir_last;
    logic disc_last;
    logic disc_zero;
  } sts_t;

endpackage

`default_nettype wire

// File: design/arc4_if.sv
`default_nettype none

interface arc4_in_if;
  logic                           valid;
  logic                           ready;
  logic [arc4_pkg::OpW-1:0]       opcode;
  logic [arc4_pkg::ByteW-1:0]     key_index;
  logic [arc4_pkg::ByteW-1:0]     key_byte;

  modport source (output valid, output opcode, output key_index, output key_byte,
                  input ready);
  modport sink   (input valid, input opcode, input key_index, input key_byte,
                  output ready);
endinterface

interface arc4_out_if;
  logic                       valid;
  logic                       ready;
  logic [arc4_pkg::ByteW-1:0] rand_byte;

  modport source (output valid, output rand_byte, input ready);
  modport sink   (input valid, input rand_byte, output ready);
endinterface

interface arc4_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [arc4_pkg::CfgIdxW-1:0]  index;
  logic [arc4_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/arc4_random_byte_generator_core.sv
// channel   dir  handshake      payload
// in_if     in   valid/ready    opcode[2:0], key_index[7:0], key_byte[7:0]
// out_if    out  valid/ready    rand_byte[7:0]
// cfg_if    in   valid/ready    index[1:0], data[11:0] (ready always high)
//
// init, load and unused opcodes finish in the idle state; generate runs one swap step, then loads the output
// stir runs 256 swap steps, discard runs drop_count swap steps
// each swap step runs read i, read j, write i, write j on the one-read one-write permutation memory
// reset gives the identity permutation at once through 256 valid bits, no sweep
// a generate result waits in the output register while the next item is taken;
// a later generate holds in its last step until that register frees up
`default_nettype none

module arc4_random_byte_generator_core #(
  parameter int unsigned KEY_BYTES = arc4_pkg::KeyBytesDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  arc4_in_if.sink     in_if,
  arc4_out_if.source  out_if,
  arc4_cfg_if.sink    cfg_if
);

  arc4_pkg::cmd_t cmd;
  arc4_pkg::sts_t sts;

  // config is always ready; a write goes straight into its register
  assign cfg_if.ready = 1'b1;

  // sequencer: one swap step at a time
  arc4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_opcode_i (in_if.opcode),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // permutation, key store, indices and config registers
  arc4_datapath #(
    .KEY_BYTES (KEY_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .key_index_i (in_if.key_index),
    .key_byte_i  (in_if.key_byte),
    .cfg_we_i    (cfg_if.valid),
    .cfg_idx_i   (cfg_if.index),
    .cfg_data_i  (cfg_if.data),
    .rand_byte_o (out_if.rand_byte)
  );

  // a new result only ever comes from an output load
  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_if.valid) |-> $past(cmd.out_ld))
    else $error("output valid rose without an output load");

  // at most one swap phase per cycle
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.rd_i, cmd.rd_j, cmd.wr_i, cmd.wr_j}))
    else $error("more than one swap phase active");

  // no item taken while a swap step runs
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rd_i || cmd.rd_j || cmd.wr_i || cmd.wr_j) |-> !in_if.ready)
    else $error("input ready during a swap step");

  // init finishes in its own cycle
  a_init_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready && in_if.opcode == arc4_pkg::OP_INIT) |=> in_if.ready)
    else $error("init did not complete in one cycle");

endmodule

`default_nettype wire

// File: design/arc4_datapath.sv
`default_nettype none

module arc4_datapath #(
  parameter int unsigned KEY_BYTES = arc4_pkg::KeyBytesDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire arc4_pkg::cmd_t                  cmd_i,
  output arc4_pkg::sts_t                       sts_o,
  input  wire logic [arc4_pkg::ByteW-1:0]      key_index_i,
  input  wire logic [arc4_pkg::ByteW-1:0]      key_byte_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [arc4_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [arc4_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic [arc4_pkg::ByteW-1:0]           rand_byte_o
);

  localparam int unsigned KeyIdxW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam logic [arc4_pkg::KeyLenW-1:0] KeyLenMax = arc4_pkg::KeyLenW'(KEY_BYTES);

  logic [7:0]   perm_mem [256];
  logic [255:0] perm_vld_q;
  logic [7:0]   key_mem [KEY_BYTES];

  logic [7:0] i_q, j_q, a_q, b_q;
  logic [7:0] i_d, j_d;
  logic [arc4_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [arc4_pkg::KeyLenW-1:0] kcnt_q, kcnt_d, kcnt_inc;
  logic [arc4_pkg::KeyLenW-1:0] key_len_q, len_eff;
  logic [arc4_pkg::DropW-1:0]   drop_q;

  logic [7:0] rd_data_q, rd_addr_q, key_rd_q, res_q, out_q;
  logic       rd_vld_q;
  logic [7:0] rd_eff, rd_addr, wr_addr, wr_data, key_add, sum_ab, gen_byte;
  logic       wr_en;

  // entries never written since init read as their own index
  assign rd_eff  = rd_vld_q ? rd_data_q : rd_addr_q;
  assign len_eff = (key_len_q == '0 || key_len_q > KeyLenMax) ? KeyLenMax : key_len_q;
  assign kcnt_inc = kcnt_q + 1'b1;
  assign key_add  = cmd_i.use_key ? key_rd_q : 8'd0;
  assign sum_ab   = a_q + b_q;

  // s[a+b] was read before both swap writes landed
  assign gen_byte = (sum_ab == j_q) ? a_q :
                    (sum_ab == i_q) ? b_q : rd_eff;

  always_comb begin
    i_d = i_q;
    j_d = j_q;
    if (cmd_i.init) begin
      i_d = '0;
      j_d = '0;
    end else if (cmd_i.stir_setup) begin
      i_d = i_q - 1'b1;
    end else if (cmd_i.rd_i) begin
      i_d = i_q + 1'b1;
    end else if (cmd_i.rd_j) begin
      j_d = j_q + rd_eff + key_add;
    end else if (cmd_i.stir_end) begin
      j_d = i_q;
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    kcnt_d = kcnt_q;
    if (cmd_i.stir_setup) begin
      cnt_d  = '0;
      kcnt_d = '0;
    end else if (cmd_i.disc_setup) begin
      cnt_d = '0;
    end else if (cmd_i.wr_j) begin
      cnt_d  = (cmd_i.stir_end || cmd_i.cnt_clr) ? '0 : cnt_q + 1'b1;
      kcnt_d = (kcnt_inc == len_eff) ? '0 : kcnt_inc;
    end
  end

  always_comb begin
    rd_addr = '0;
    if (cmd_i.rd_i) begin
      rd_addr = i_q + 1'b1;
    end else if (cmd_i.rd_j) begin
      rd_addr = j_d;
    end else if (cmd_i.wr_i) begin
      rd_addr = a_q + rd_eff;
    end
  end

  assign wr_en   = cmd_i.wr_i | cmd_i.wr_j;
  assign wr_addr = cmd_i.wr_i ? i_q : j_q;
  assign wr_data = cmd_i.wr_i ? rd_eff : a_q;

  assign sts_o.stir_last = (cnt_q == arc4_pkg::CntW'(255));
  assign sts_o.disc_last = ({1'b0, cnt_q} + 1'b1) == {1'b0, drop_q};
  assign sts_o.disc_zero = (drop_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q        <= '0;
      j_q        <= '0;
      cnt_q      <= '0;
      kcnt_q     <= '0;
      perm_vld_q <= '0;
      key_len_q  <= arc4_pkg::KeyLenRst;
      drop_q     <= arc4_pkg::DropRst;
    end else begin
      i_q    <= i_d;
      j_q    <= j_d;
      cnt_q  <= cnt_d;
      kcnt_q <= kcnt_d;
      if (cmd_i.init) begin
        perm_vld_q <= '0;
      end else if (wr_en) begin
        perm_vld_q[wr_addr] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          arc4_pkg::CFG_KEY_LEN: key_len_q <= cfg_data_i[arc4_pkg::KeyLenW-1:0];
          arc4_pkg::CFG_DROP:    drop_q    <= cfg_data_i[arc4_pkg::DropW-1:0];
          default: ;
        endcase
      end
    end
  end

  // permutation memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      perm_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= perm_mem[rd_addr];
    rd_vld_q  <= perm_vld_q[rd_addr];
    rd_addr_q <= rd_addr;
  end

  // key store
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_wr && ({1'b0, key_index_i} < KeyLenMax)) begin
      key_mem[key_index_i[KeyIdxW-1:0]] <= key_byte_i;
    end
    key_rd_q <= key_mem[kcnt_q[KeyIdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_j) begin
      a_q <= rd_eff;
    end
    if (cmd_i.wr_i) begin
      b_q <= rd_eff;
    end
    if (cmd_i.wr_j) begin
      res_q <= gen_byte;
    end
    if (cmd_i.out_ld) begin
      out_q <= cmd_i.out_from_res ? res_q : gen_byte;
    end
  end

  assign rand_byte_o = out_q;

endmodule

`default_nettype wire

// File: design/arc4_ctrl.sv
`default_nettype none

module arc4_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [arc4_pkg::OpW-1:0]    in_opcode_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  input  wire arc4_pkg::sts_t              sts_i,
  output arc4_pkg::cmd_t                   cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_I,
    ST_RD_J,
    ST_WR_I,
    ST_WR_J,
    ST_HOLD
  } state_e;

  state_e            state_q, state_d;
  arc4_pkg::op_e     op_q, op_d;
  logic              out_valid_q, out_valid_d;
  logic              accept, out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    op_d        = op_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d = arc4_pkg::op_e'(in_opcode_i);
          case (in_opcode_i)
            arc4_pkg::OP_INIT: cmd_o.init = 1'b1;
            arc4_pkg::OP_LOAD: cmd_o.key_wr = 1'b1;
            arc4_pkg::OP_STIR: begin
              cmd_o.stir_setup = 1'b1;
              state_d = ST_RD_I;
            end
            arc4_pkg::OP_DISC: begin
              if (!sts_i.disc_zero) begin
                cmd_o.disc_setup = 1'b1;
                state_d = ST_RD_I;
              end
            end
            arc4_pkg::OP_GEN: state_d = ST_RD_I;
            default: ;
          endcase
        end
      end
      ST_RD_I: begin
        cmd_o.rd_i = 1'b1;
        state_d = ST_RD_J;
      end
      ST_RD_J: begin
        cmd_o.rd_j    = 1'b1;
        cmd_o.use_key = (op_q == arc4_pkg::OP_STIR);
        state_d = ST_WR_I;
      end
      ST_WR_I: begin
        cmd_o.wr_i = 1'b1;
        state_d = ST_WR_J;
      end
      ST_WR_J: begin
        cmd_o.wr_j = 1'b1;
        case (op_q)
          arc4_pkg::OP_STIR: begin
            if (sts_i.stir_last) begin
              cmd_o.stir_end = 1'b1;
              state_d = ST_IDLE;
            end else begin
              state_d = ST_RD_I;
            end
          end
          arc4_pkg::OP_DISC: begin
            if (sts_i.disc_last) begin
              cmd_o.cnt_clr = 1'b1;
              state_d = ST_IDLE;
            end else begin
              state_d = ST_RD_I;
            end
          end
          default: begin
            if (out_free) begin
              cmd_o.out_ld = 1'b1;
              out_valid_d  = 1'b1;
              state_d = ST_IDLE;
            end else begin
              state_d = ST_HOLD;
            end
          end
        endcase
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd_o.out_ld       = 1'b1;
          cmd_o.out_from_res = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= arc4_pkg::OP_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: verif/arc4_keystream_checker.sv
module arc4_keystream_checker
  import arc4_pkg::*;
#(
  parameter int unsigned KEY_BYTES = KeyBytesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  arc4_in_if   in_if,
  arc4_out_if  out_if,
  arc4_cfg_if  cfg_if,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ReportMax = 10;

  logic [ByteW-1:0]   perm [256];
  logic [ByteW-1:0]   key_mem [KEY_BYTES];
  logic [ByteW-1:0]   idx_i;
  logic [ByteW-1:0]   idx_j;
  logic [KeyLenW-1:0] key_len;
  logic [DropW-1:0]   drop_cnt;
  logic [ByteW-1:0]   keystream_q [$];
  logic [ByteW-1:0]   want_byte;
  int                 fails;

  function automatic void reset_cipher();
    for (int n = 0; n < 256; n++) perm[n] = ByteW'(n);
    idx_i = '0;
    idx_j = '0;
  endfunction

  function automatic logic [ByteW-1:0] keystream_step();
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] sum;
    idx_i = idx_i + 1'b1;
    a = perm[idx_i];
    idx_j = idx_j + a;
    b = perm[idx_j];
    perm[idx_i] = b;
    perm[idx_j] = a;
    sum = a + b;
    return perm[sum];
  endfunction

  // key schedule: i steps back once, 256 swaps, then j follows i
  function automatic void mix_key();
    int unsigned      span;
    logic [ByteW-1:0] a;
    span = (key_len == '0 || int'(key_len) > KEY_BYTES) ? KEY_BYTES : int'(key_len);
    idx_i = idx_i - 1'b1;
    for (int unsigned n = 0; n < 256; n++) begin
      idx_i = idx_i + 1'b1;
      a = perm[idx_i];
      idx_j = idx_j + a + key_mem[n % span];
      perm[idx_i] = perm[idx_j];
      perm[idx_j] = a;
    end
    idx_j = idx_i;
  endfunction

  function automatic void report_miss(input string what);
    if (fails < ReportMax) $display("%0t mismatch: %s", $time, what);
    fails++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_cipher();
      key_len  = KeyLenRst;
      drop_cnt = DropRst;
      for (int n = 0; n < KEY_BYTES; n++) key_mem[n] = '0;
      keystream_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // results first: a byte leaving now never belongs to an item taken now
      if (out_if.valid && out_if.ready) begin
        if (keystream_q.size() == 0) begin
          report_miss($sformatf("rand_byte %02h with none expected", out_if.rand_byte));
        end else begin
          want_byte = keystream_q.pop_front();
          if (out_if.rand_byte !== want_byte)
            report_miss($sformatf("rand_byte expected %02h got %02h",
                                  want_byte, out_if.rand_byte));
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_KEY_LEN: key_len  = cfg_if.data[KeyLenW-1:0];
          CFG_DROP:    drop_cnt = cfg_if.data[DropW-1:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        case (in_if.opcode)
          OP_INIT: reset_cipher();
          OP_LOAD: begin
            if (int'(in_if.key_index) < KEY_BYTES) key_mem[in_if.key_index] = in_if.key_byte;
          end
          OP_STIR: mix_key();
          OP_DISC: for (int n = 0; n < int'(drop_cnt); n++) void'(keystream_step());
          OP_GEN:  keystream_q.push_back(keystream_step());
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o    <= keystream_q.size();
    end
  end

endmodule

// File: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import arc4_pkg::*;

  localparam int unsigned KeyBytes   = KeyBytesDef;
  localparam int unsigned HalfPeriod = 5;
  localparam int unsigned RstCycles  = 5;
  localparam int unsigned StallLimit = 200000;  // cycles with no handshake at all
  localparam int unsigned HoldCycles = 400;     // long receiver hold-off
  localparam int unsigned SqueezeGen = 24;

  // opcodes and register indexes the block must ignore
  localparam logic [OpW-1:0]     OpSpareLo  = 3'd5;
  localparam logic [OpW-1:0]     OpSpareHi  = 3'd7;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  typedef struct {
    int unsigned klen;
    int unsigned drop;
    int unsigned tx_idle;
    int unsigned rx_stall;
    int unsigned items;
    bit          squeeze;
  } phase_t;

  // phase 0 runs on the reset register values
  // key lengths 0, 300 and 511 all behave as a full key
  phase_t plan [8] = '{
    '{128, 1024,  0,  0, 180, 1'b0},
    '{  1,    0, 88,  0, 200, 1'b0},
    '{256, 4095,  0, 88, 150, 1'b0},
    '{  0,    3,  8,  8, 200, 1'b0},
    '{300,    1,  0,  0, 200, 1'b1},
    '{  2,   17, 88,  0, 200, 1'b0},
    '{511,  255,  0, 88, 200, 1'b0},
    '{255,   64,  8,  8, 200, 1'b0}
  };

  logic        clk;
  logic        rst_n;
  int          fail_count;
  int          pending;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  bit          hold_req;
  bit          key_written [KeyBytes];
  int unsigned cur_klen;
  int unsigned cur_drop;

  arc4_in_if  in_bus ();
  arc4_out_if out_bus ();
  arc4_cfg_if cfg_bus ();

  initial clk = 1'b0;
  always #(HalfPeriod) clk = ~clk;

  arc4_random_byte_generator_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  arc4_keystream_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_if        (in_bus),
    .out_if       (out_bus),
    .cfg_if       (cfg_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end
      out_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // watchdog: ends the run when no channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // offer one item after a random idle gap; returns once it is taken
  task automatic send_item(input logic [OpW-1:0] op, input logic [ByteW-1:0] kidx,
                           input logic [ByteW-1:0] kbyte);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_bus.valid     <= 1'b1;
    in_bus.opcode    <= op;
    in_bus.key_index <= kidx;
    in_bus.key_byte  <= kbyte;
    do @(posedge clk); while (!in_bus.ready);
    if (op == OP_LOAD) key_written[kidx] = 1'b1;
  endtask

  task automatic send_op(input logic [OpW-1:0] op);
    send_item(op, ByteW'($urandom), ByteW'($urandom));
  endtask

  // a stir only ever reads key entries that have been loaded
  task automatic send_stir();
    int unsigned span;
    span = (cur_klen == 0 || cur_klen > KeyBytes) ? KeyBytes : cur_klen;
    for (int unsigned k = 0; k < span; k++)
      if (!key_written[k]) send_item(OP_LOAD, ByteW'(k), ByteW'($urandom));
    send_op(OP_STIR);
  endtask

  // mostly generate and load, some key schedules, resets and drops, rare junk
  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 2)       send_op(OpW'($urandom_range(OpSpareHi, OpSpareLo)));
    else if (pick < 5)  send_op(OP_INIT);
    else if (pick < 9)  send_stir();
    else if (pick < 12) send_op(OP_DISC);
    else if (pick < 32) send_op(OP_LOAD);
    else                send_op(OP_GEN);
  endtask

  // sender holds off until every expected byte is back
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // drain, then give a running stir or discard time to finish
  task automatic quiesce();
    drain();
    repeat (4 * ((cur_drop > 256) ? cur_drop : 256) + 64) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  // both registers, with a write to an unused index in between
  task automatic set_config(input logic [KeyLenW-1:0] klen, input logic [DropW-1:0] drop);
    put_reg(CFG_KEY_LEN, {(CfgDataW-KeyLenW)'($urandom), klen});
    put_reg(CfgIdxW'($urandom_range(CfgSpareHi, CfgSpareLo)), CfgDataW'($urandom));
    put_reg(CFG_DROP, drop);
    cfg_bus.valid <= 1'b0;
    cur_klen = klen;
    cur_drop = drop;
  endtask

  initial begin : stimulus
    in_bus.valid     <= 1'b0;
    in_bus.opcode    <= OP_INIT;
    in_bus.key_index <= '0;
    in_bus.key_byte  <= '0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= CFG_KEY_LEN;
    cfg_bus.data     <= '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req     = 1'b0;
    cur_klen     = KeyLenRst;
    cur_drop     = DropRst;
    rst_n = 1'b0;
    repeat (RstCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // keystream straight out of reset, then a drop with the reset count
    send_item(OP_GEN, 8'h00, 8'h00);
    send_item(OP_GEN, 8'hff, 8'hff);
    send_op(OP_DISC);
    send_op(OP_GEN);
    // key store corners
    send_item(OP_LOAD, 8'h00, 8'hff);
    send_item(OP_LOAD, 8'hff, 8'h00);
    send_item(OP_LOAD, 8'h80, 8'h5a);
    // unused opcodes must leave the state alone
    for (int unsigned op = OpSpareLo; op <= OpSpareHi; op++) send_op(OpW'(op));
    send_op(OP_GEN);
    // init restarts the identity stream, keys survive it
    send_op(OP_INIT);
    send_op(OP_GEN);
    send_op(OP_GEN);
    send_op(OP_INIT);
    send_op(OP_INIT);
    send_op(OP_GEN);

    foreach (plan[p]) begin
      if (p != 0) begin
        quiesce();
        set_config(KeyLenW'(plan[p].klen), DropW'(plan[p].drop));
      end
      tx_idle_pct  = plan[p].tx_idle;
      rx_stall_pct = plan[p].rx_stall;
      if (plan[p].squeeze) begin
        // receiver sits still while generates keep coming, block backs up
        hold_req = 1'b1;
        repeat (SqueezeGen) send_op(OP_GEN);
        drain();
      end
      repeat (plan[p].items) send_random_item();
    end

    quiesce();
    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
